>>> sv/qrgr_pkg.sv
// Package for the Givens QR rotation unit: widths and register indexes
// shared by the top level and checkers; fixed-point helpers for the top.
// No dependencies.
package qrgr_pkg;

  localparam int MAX_SIZE  = 4;
  localparam int IDX_W     = 2;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DEPTH     = MAX_SIZE * MAX_SIZE;
  localparam int DATA_W    = 32;
  localparam int SIZE_W    = 3;
  localparam int NORM_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_NORM = 2'd1;

  localparam logic [DATA_W-1:0] ONE_Q16 = 32'h0001_0000;

  typedef logic signed [DATA_W-1:0] word_t;

  // Q32.32 to Q16.16: round half up, saturate
  function automatic word_t scale_down(input logic signed [63:0] x);
    logic signed [63:0] t;
    logic signed [47:0] h;
    t = x + 64'sd32768;
    h = t[63:16];
    if (h > 48'sh0000_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end
    if (h < 48'shFFFF_8000_0000) begin
      return 32'sh8000_0000;
    end
    return h[31:0];
  endfunction

  function automatic logic [DATA_W-1:0] mag(input word_t x);
    logic [DATA_W:0] e;
    logic [DATA_W:0] m;
    e = {x[DATA_W-1], x};
    m = x[DATA_W-1] ? (~e + 1'b1) : e;
    return m[DATA_W-1:0];
  endfunction

endpackage

>>> sv/qr_givens_rotation_unit.sv
// Givens QR rotation unit: loads A, decomposes it into Q and R and
// streams Q then R. Depends on qrgr_pkg.
//
// Usage:
//   in channel  : in_valid_i / in_ready_o with value_i, the elements of A in
//                 row-major order, n*n requests per matrix (n = size_in_use,
//                 0 read as 1, above 4 read as 4).
//   out channel : out_valid_o / out_ready_i with which_matrix_o, row_o,
//                 col_o, element_o, last_o; 2*n*n requests per matrix, Q
//                 first, last_o on the final element of R.
//   cfg channel : cfg_valid_i / cfg_ready_o (always ready), cfg_index_i,
//                 cfg_data_i. Writing size_in_use restarts loading.
// Operation: elements are taken back to back while in_ready_o is high. After
//   the last element the unit sets Q to identity, then per row pair forms
//   the norm (32-step root in the shared square-root loop), runs the two
//   17-step divisions for c and s and rotates the rows of R and Q through
//   the single shared multiplier; a skipped pair ends after the norm. Output
//   is one element per cycle while the receiver takes them; a stall holds the
//   output register and the sequencer. in_ready_o is low from the last element
//   of A until the last element of R has been placed in the output register.
// Reset: size 4, min_norm 0, loading restarts; stores are not cleared.
module qr_givens_rotation_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  qrgr_pkg::word_t                 value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            which_matrix_o,
  output logic [qrgr_pkg::IDX_W-1:0]      row_o,
  output logic [qrgr_pkg::IDX_W-1:0]      col_o,
  output qrgr_pkg::word_t                 element_o,
  output logic                            last_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [qrgr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [qrgr_pkg::NORM_W-1:0]     cfg_data_i
);
  import qrgr_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_QINIT = 5'd1;
  localparam logic [4:0] S_RDX   = 5'd2;
  localparam logic [4:0] S_RDY   = 5'd3;
  localparam logic [4:0] S_SQ1   = 5'd4;
  localparam logic [4:0] S_SQ2   = 5'd5;
  localparam logic [4:0] S_SQ3   = 5'd6;
  localparam logic [4:0] S_SQRT  = 5'd7;
  localparam logic [4:0] S_CMP   = 5'd8;
  localparam logic [4:0] S_DIVC  = 5'd9;
  localparam logic [4:0] S_DIVS  = 5'd10;
  localparam logic [4:0] S_LDA   = 5'd11;
  localparam logic [4:0] S_LDB   = 5'd12;
  localparam logic [4:0] S_P1    = 5'd13;
  localparam logic [4:0] S_P2    = 5'd14;
  localparam logic [4:0] S_P3    = 5'd15;
  localparam logic [4:0] S_P4    = 5'd16;
  localparam logic [4:0] S_W     = 5'd17;
  localparam logic [4:0] S_OUT   = 5'd18;

  logic [4:0]        state_q, state_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [NORM_W-1:0] min_norm_q, min_norm_d;
  logic [IDX_W-1:0]  lrow_q, lrow_d, lcol_q, lcol_d;
  logic [IDX_W-1:0]  k_q, k_d, i_q, i_d, j_q, j_d;
  logic              mat_q, mat_d;
  logic [4:0]        cnt_q, cnt_d;
  logic              owhich_q, owhich_d;
  logic [IDX_W-1:0]  orow_q, orow_d, ocol_q, ocol_d;
  logic              ovalid_q, ovalid_d;
  logic              olast_q, olast_d;
  logic [IDX_W-1:0]  orow_out_q, orow_out_d, ocol_out_q, ocol_out_d;
  logic              owhich_out_q, owhich_out_d;
  word_t             oelem_q, oelem_d;

  word_t             xi_q, xi_d, xj_q, xj_d, a_q, a_d, b_q, b_d;
  logic [63:0]       acc_q, acc_d;
  logic signed [63:0] prod_q, prod_d;
  logic [35:0]       rem_q, rem_d;
  logic [31:0]       root_q, root_d;
  logic [16:0]       quo_q, quo_d;
  logic signed [17:0] c_q, c_d, s_q, s_d;

  word_t             r_q [DEPTH];
  word_t             q_q [DEPTH];
  logic              r_we, q_we;
  logic [ADDR_W-1:0] w_addr, rd_addr;
  word_t             w_data, rd_r, rd_q, rd_m;

  logic [SIZE_W-1:0] n_eff, nm1_w;
  logic [IDX_W-1:0]  nm1;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [35:0]       sq_rem, sq_trial, sq_sub;
  logic              sq_ge;
  logic              dv_ge;
  logic [35:0]       dv_sub;
  logic [16:0]       dv_quo;
  logic              last_pair, out_free;
  logic [IDX_W-1:0]  k_inc;

  always_comb begin
    if (size_q == '0) begin
      n_eff = SIZE_W'(1);
    end else if (size_q > SIZE_W'(MAX_SIZE)) begin
      n_eff = SIZE_W'(MAX_SIZE);
    end else begin
      n_eff = size_q;
    end
  end
  assign nm1_w = n_eff - SIZE_W'(1);
  assign nm1   = nm1_w[IDX_W-1:0];

  assign rd_r  = r_q[rd_addr];
  assign rd_q  = q_q[rd_addr];
  assign rd_m  = mat_q ? rd_q : rd_r;
  assign mul_p = mul_a * mul_b;

  assign sq_rem   = {rem_q[33:0], acc_q[63:62]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign sq_ge    = sq_rem >= sq_trial;
  assign sq_sub   = sq_ge ? (sq_rem - sq_trial) : sq_rem;

  assign dv_ge  = rem_q >= {4'b0000, root_q};
  assign dv_sub = dv_ge ? (rem_q - {4'b0000, root_q}) : rem_q;
  assign dv_quo = {quo_q[15:0], dv_ge};

  assign k_inc     = k_q + 1'b1;
  assign last_pair = (i_q == nm1) && (k_inc == nm1);
  assign out_free  = !ovalid_q || out_ready_i;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d      = state_q;
    size_d       = size_q;
    min_norm_d   = min_norm_q;
    lrow_d       = lrow_q;
    lcol_d       = lcol_q;
    k_d          = k_q;
    i_d          = i_q;
    j_d          = j_q;
    mat_d        = mat_q;
    cnt_d        = cnt_q;
    owhich_d     = owhich_q;
    orow_d       = orow_q;
    ocol_d       = ocol_q;
    ovalid_d     = ovalid_q && !out_ready_i;
    olast_d      = olast_q;
    orow_out_d   = orow_out_q;
    ocol_out_d   = ocol_out_q;
    owhich_out_d = owhich_out_q;
    oelem_d      = oelem_q;
    xi_d         = xi_q;
    xj_d         = xj_q;
    a_d          = a_q;
    b_d          = b_q;
    acc_d        = acc_q;
    prod_d       = prod_q;
    rem_d        = rem_q;
    root_d       = root_q;
    quo_d        = quo_q;
    c_d          = c_q;
    s_d          = s_q;
    r_we         = 1'b0;
    q_we         = 1'b0;
    w_addr       = '0;
    w_data       = '0;
    rd_addr      = '0;
    mul_a        = '0;
    mul_b        = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          r_we   = 1'b1;
          w_addr = {lrow_q, lcol_q};
          w_data = value_i;
          if (lcol_q == nm1) begin
            lcol_d = '0;
            if (lrow_q == nm1) begin
              lrow_d  = '0;
              cnt_d   = '0;
              state_d = S_QINIT;
            end else begin
              lrow_d = lrow_q + 1'b1;
            end
          end else begin
            lcol_d = lcol_q + 1'b1;
          end
        end
      end
      S_QINIT: begin
        q_we   = 1'b1;
        w_addr = cnt_q[ADDR_W-1:0];
        w_data = (w_addr[ADDR_W-1:IDX_W] == w_addr[IDX_W-1:0]) ? ONE_Q16 : '0;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q[ADDR_W-1:0] == ADDR_W'(DEPTH - 1)) begin
          k_d      = '0;
          i_d      = IDX_W'(1);
          owhich_d = 1'b0;
          orow_d   = '0;
          ocol_d   = '0;
          state_d  = (nm1 == '0) ? S_OUT : S_RDX;
        end
      end
      S_RDX: begin
        rd_addr = {k_q, k_q};
        xi_d    = rd_r;
        state_d = S_RDY;
      end
      S_RDY: begin
        rd_addr = {i_q, k_q};
        xj_d    = rd_r;
        state_d = S_SQ1;
      end
      S_SQ1: begin
        mul_a   = $signed({1'b0, mag(xi_q)});
        mul_b   = $signed({1'b0, mag(xi_q)});
        prod_d  = mul_p[63:0];
        state_d = S_SQ2;
      end
      S_SQ2: begin
        mul_a   = $signed({1'b0, mag(xj_q)});
        mul_b   = $signed({1'b0, mag(xj_q)});
        prod_d  = mul_p[63:0];
        acc_d   = prod_q;
        state_d = S_SQ3;
      end
      S_SQ3: begin
        acc_d   = acc_q + prod_q;
        rem_d   = '0;
        root_d  = '0;
        cnt_d   = 5'd31;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        rem_d  = sq_sub;
        root_d = {root_q[30:0], sq_ge};
        acc_d  = {acc_q[61:0], 2'b00};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (root_q > {16'h0000, min_norm_q}) begin
          rem_d   = {4'b0000, mag(xi_q)};
          quo_d   = '0;
          cnt_d   = 5'd16;
          state_d = S_DIVC;
        end else if (last_pair) begin
          owhich_d = 1'b0;
          orow_d   = '0;
          ocol_d   = '0;
          state_d  = S_OUT;
        end else begin
          if (i_q != nm1) begin
            i_d = i_q + 1'b1;
          end else begin
            k_d = k_inc;
            i_d = k_inc + 1'b1;
          end
          state_d = S_RDX;
        end
      end
      S_DIVC: begin
        rem_d = {dv_sub[34:0], 1'b0};
        quo_d = dv_quo;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          c_d     = xi_q[DATA_W-1] ? -$signed({1'b0, dv_quo}) : $signed({1'b0, dv_quo});
          rem_d   = {4'b0000, mag(xj_q)};
          quo_d   = '0;
          cnt_d   = 5'd16;
          state_d = S_DIVS;
        end
      end
      S_DIVS: begin
        rem_d = {dv_sub[34:0], 1'b0};
        quo_d = dv_quo;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          s_d     = xj_q[DATA_W-1] ? -$signed({1'b0, dv_quo}) : $signed({1'b0, dv_quo});
          j_d     = '0;
          mat_d   = 1'b0;
          state_d = S_LDA;
        end
      end
      S_LDA: begin
        rd_addr = {k_q, j_q};
        a_d     = rd_m;
        state_d = S_LDB;
      end
      S_LDB: begin
        rd_addr = {i_q, j_q};
        b_d     = rd_m;
        state_d = S_P1;
      end
      S_P1: begin
        mul_a   = {{15{c_q[17]}}, c_q};
        mul_b   = {a_q[DATA_W-1], a_q};
        prod_d  = mul_p[63:0];
        state_d = S_P2;
      end
      S_P2: begin
        mul_a   = {{15{s_q[17]}}, s_q};
        mul_b   = {b_q[DATA_W-1], b_q};
        prod_d  = mul_p[63:0];
        acc_d   = prod_q;
        state_d = S_P3;
      end
      S_P3: begin
        mul_a   = {{15{c_q[17]}}, c_q};
        mul_b   = {b_q[DATA_W-1], b_q};
        prod_d  = mul_p[63:0];
        r_we    = !mat_q;
        q_we    = mat_q;
        w_addr  = {k_q, j_q};
        w_data  = scale_down($signed(acc_q) + prod_q);
        state_d = S_P4;
      end
      S_P4: begin
        mul_a   = {{15{s_q[17]}}, s_q};
        mul_b   = {a_q[DATA_W-1], a_q};
        prod_d  = mul_p[63:0];
        acc_d   = prod_q;
        state_d = S_W;
      end
      S_W: begin
        r_we   = !mat_q;
        q_we   = mat_q;
        w_addr = {i_q, j_q};
        w_data = scale_down($signed(acc_q) - prod_q);
        if (j_q != nm1) begin
          j_d     = j_q + 1'b1;
          state_d = S_LDA;
        end else if (!mat_q) begin
          j_d     = '0;
          mat_d   = 1'b1;
          state_d = S_LDA;
        end else if (last_pair) begin
          owhich_d = 1'b0;
          orow_d   = '0;
          ocol_d   = '0;
          state_d  = S_OUT;
        end else begin
          if (i_q != nm1) begin
            i_d = i_q + 1'b1;
          end else begin
            k_d = k_inc;
            i_d = k_inc + 1'b1;
          end
          state_d = S_RDX;
        end
      end
      S_OUT: begin
        rd_addr = owhich_q ? {orow_q, ocol_q} : {ocol_q, orow_q};
        if (out_free) begin
          ovalid_d     = 1'b1;
          owhich_out_d = owhich_q;
          orow_out_d   = orow_q;
          ocol_out_d   = ocol_q;
          oelem_d      = owhich_q ? rd_r : rd_q;
          olast_d      = owhich_q && (orow_q == nm1) && (ocol_q == nm1);
          if (ocol_q == nm1) begin
            ocol_d = '0;
            if (orow_q == nm1) begin
              orow_d = '0;
              if (owhich_q) begin
                state_d = S_IDLE;
              end else begin
                owhich_d = 1'b1;
              end
            end else begin
              orow_d = orow_q + 1'b1;
            end
          end else begin
            ocol_d = ocol_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SIZE: begin
          size_d = cfg_data_i[SIZE_W-1:0];
          lrow_d = '0;
          lcol_d = '0;
        end
        CFG_MIN_NORM: begin
          min_norm_d = cfg_data_i;
        end
        default: begin
          min_norm_d = min_norm_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      size_q     <= SIZE_W'(MAX_SIZE);
      min_norm_q <= '0;
      lrow_q     <= '0;
      lcol_q     <= '0;
      k_q        <= '0;
      i_q        <= '0;
      j_q        <= '0;
      mat_q      <= 1'b0;
      cnt_q      <= '0;
      owhich_q   <= 1'b0;
      orow_q     <= '0;
      ocol_q     <= '0;
      ovalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      size_q     <= size_d;
      min_norm_q <= min_norm_d;
      lrow_q     <= lrow_d;
      lcol_q     <= lcol_d;
      k_q        <= k_d;
      i_q        <= i_d;
      j_q        <= j_d;
      mat_q      <= mat_d;
      cnt_q      <= cnt_d;
      owhich_q   <= owhich_d;
      orow_q     <= orow_d;
      ocol_q     <= ocol_d;
      ovalid_q   <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    olast_q      <= olast_d;
    orow_out_q   <= orow_out_d;
    ocol_out_q   <= ocol_out_d;
    owhich_out_q <= owhich_out_d;
    oelem_q      <= oelem_d;
    xi_q         <= xi_d;
    xj_q         <= xj_d;
    a_q          <= a_d;
    b_q          <= b_d;
    acc_q        <= acc_d;
    prod_q       <= prod_d;
    rem_q        <= rem_d;
    root_q       <= root_d;
    quo_q        <= quo_d;
    c_q          <= c_d;
    s_q          <= s_d;
    if (r_we) begin
      r_q[w_addr] <= w_data;
    end
    if (q_we) begin
      q_q[w_addr] <= w_data;
    end
  end

  assign out_valid_o    = ovalid_q;
  assign which_matrix_o = owhich_out_q;
  assign row_o          = orow_out_q;
  assign col_o          = ocol_out_q;
  assign element_o      = oelem_q;
  assign last_o         = olast_q;

endmodule

>>> sv/qrgr_checker.sv
// Port-level checker for the Givens QR rotation unit, bound to the top level.
// Depends on qrgr_pkg and qr_givens_rotation_unit.
module qrgr_port_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [qrgr_pkg::IDX_W-1:0]     row_o,
  input logic [qrgr_pkg::IDX_W-1:0]     col_o,
  input qrgr_pkg::word_t                element_o,
  input logic                           last_o,
  input logic                           cfg_ready_o
);
  import qrgr_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(element_o)
      && $stable(row_o) && $stable(col_o))
    else $error("stalled output request changed");

  a_busy_while_streaming: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input taken while results still streaming");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_o |=> !out_valid_o)
    else $error("output request straight after last");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind qr_givens_rotation_unit qrgr_port_checker u_qrgr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .row_o       (row_o),
  .col_o       (col_o),
  .element_o   (element_o),
  .last_o      (last_o),
  .cfg_ready_o (cfg_ready_o)
);

>>> dv/qrgr_checker.sv
// Checker for the Givens QR rotation unit: watches the request, result and
// register channels, predicts Q and R in Q16.16 and compares every result.
// Depends on qrgr_pkg.
`timescale 1ns / 1ps

module qrgr_checker
  import qrgr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  word_t                value_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic                 which_matrix_i,
  input  logic [IDX_W-1:0]     row_i,
  input  logic [IDX_W-1:0]     col_i,
  input  word_t                element_i,
  input  logic                 last_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [NORM_W-1:0]    cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct {
    logic             which;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    word_t            element;
    logic             last;
  } elem_t;

  elem_t             result_q[$];
  logic [SIZE_W-1:0] order_reg;
  logic [NORM_W-1:0] norm_floor;
  int                fill;
  word_t             r_mat[DEPTH];
  word_t             q_mat[DEPTH];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic int order_used();
    if (order_reg == '0) return 1;
    if (order_reg > MAX_SIZE) return MAX_SIZE;
    return int'(order_reg);
  endfunction

  function automatic logic [63:0] abs_word(input word_t x);
    logic signed [63:0] e;
    e = x;
    return (e < 0) ? -e : e;
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] rem;
    r   = '0;
    rem = v;
    b   = 64'h4000_0000_0000_0000;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] quotient(input word_t x, input logic [63:0] u);
    logic signed [63:0] q;
    q = signed'((abs_word(x) << 16) / u);
    return (x < 0) ? -q : q;
  endfunction

  function automatic word_t to_q16(input logic signed [63:0] x);
    logic signed [63:0] t;
    t = (x + 64'sd32768) >>> 16;
    if (t > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (t < -64'sd2147483648) return 32'sh8000_0000;
    return t[31:0];
  endfunction

  function automatic void rotate_pair(input int n, input int k, input int i,
                                      input logic signed [63:0] c,
                                      input logic signed [63:0] s);
    logic signed [63:0] a;
    logic signed [63:0] b;
    for (int j = 0; j < n; j++) begin
      a = r_mat[k*MAX_SIZE+j];
      b = r_mat[i*MAX_SIZE+j];
      r_mat[k*MAX_SIZE+j] = to_q16(c * a + s * b);
      r_mat[i*MAX_SIZE+j] = to_q16(c * b - s * a);
      a = q_mat[k*MAX_SIZE+j];
      b = q_mat[i*MAX_SIZE+j];
      q_mat[k*MAX_SIZE+j] = to_q16(c * a + s * b);
      q_mat[i*MAX_SIZE+j] = to_q16(c * b - s * a);
    end
  endfunction

  function automatic void factorise(input int n);
    word_t       xk;
    word_t       xi;
    logic [63:0] u;
    elem_t       e;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        q_mat[i*MAX_SIZE+j] = (i == j) ? ONE_Q16 : '0;
    for (int k = 0; k < n; k++) begin
      for (int i = k + 1; i < n; i++) begin
        xk = r_mat[k*MAX_SIZE+k];
        xi = r_mat[i*MAX_SIZE+k];
        u  = root_floor(abs_word(xk) * abs_word(xk) + abs_word(xi) * abs_word(xi));
        if (u > {48'b0, norm_floor}) rotate_pair(n, k, i, quotient(xk, u), quotient(xi, u));
      end
    end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        e = '{1'b0, IDX_W'(i), IDX_W'(j), q_mat[j*MAX_SIZE+i], 1'b0};
        result_q.push_back(e);
      end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        e = '{1'b1, IDX_W'(i), IDX_W'(j), r_mat[i*MAX_SIZE+j],
              (i == n - 1 && j == n - 1)};
        result_q.push_back(e);
      end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    elem_t exp_e;
    int    n;
    if (!rst_ni) begin
      order_reg  = 3'd4;
      norm_floor = '0;
      fill       = 0;
      result_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SIZE: begin
            order_reg = cfg_data_i[SIZE_W-1:0];
            fill      = 0;
          end
          CFG_MIN_NORM: norm_floor = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        n = order_used();
        if (fill >= n * n) fill = 0;
        r_mat[(fill / n) * MAX_SIZE + (fill % n)] = value_i;
        fill++;
        if (fill == n * n) begin
          fill = 0;
          factorise(n);
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          $error("result with nothing expected: row %0d col %0d", row_i, col_i);
          fail_count_o++;
        end else begin
          exp_e = result_q.pop_front();
          if (which_matrix_i !== exp_e.which) begin
            $error("which_matrix expected %0d actual %0d", exp_e.which, which_matrix_i);
            fail_count_o++;
          end
          if (row_i !== exp_e.row) begin
            $error("row expected %0d actual %0d", exp_e.row, row_i);
            fail_count_o++;
          end
          if (col_i !== exp_e.col) begin
            $error("col expected %0d actual %0d", exp_e.col, col_i);
            fail_count_o++;
          end
          if (element_i !== exp_e.element) begin
            $error("element expected %h actual %h", exp_e.element, element_i);
            fail_count_o++;
          end
          if (last_i !== exp_e.last) begin
            $error("last expected %0d actual %0d", exp_e.last, last_i);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = result_q.size();
  end

endmodule

>>> dv/tb_qr_givens_rotation_unit.sv
// Top of the Givens QR rotation unit testbench: clock, reset, matrix and
// register stimulus, receiver stalls and verdict. Depends on qrgr_pkg,
// qrgr_checker and qr_givens_rotation_unit.
`timescale 1ns / 1ps

module tb_qr_givens_rotation_unit;
  import qrgr_pkg::*;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  word_t                value_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 which_matrix_o;
  logic [IDX_W-1:0]     row_o;
  logic [IDX_W-1:0]     col_o;
  word_t                element_o;
  logic                 last_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [NORM_W-1:0]    cfg_data_i;
  int                   fail_count;
  int                   pending;
  logic                 in_taken  = 1'b0;
  logic                 cfg_taken = 1'b0;
  int                   burst_left = 0;
  int                   requests_sent = 0;

  qr_givens_rotation_unit u_dut (.*);

  qrgr_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .value_i,
    .out_valid_i(out_valid_o), .out_ready_i, .which_matrix_i(which_matrix_o),
    .row_i(row_o), .col_i(col_o), .element_i(element_o), .last_i(last_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    in_taken  <= in_valid_i && in_ready_o;
    cfg_taken <= cfg_valid_i && cfg_ready_o;
  end

  initial begin
    int cyc;
    out_ready_i = 1'b0;
    cyc = 0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc == 3000) begin
        out_ready_i <= 1'b0;
        repeat (700) @(negedge clk_i);
      end else if ((cyc / 200) % 3 == 0) begin
        out_ready_i <= 1'b1;
      end else if ((cyc / 200) % 3 == 1) begin
        out_ready_i <= ($urandom_range(0, 1) == 1);
      end else begin
        out_ready_i <= ($urandom_range(0, 4) == 0);
      end
    end
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  task automatic send_element(input word_t v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    @(negedge clk_i);
    while (!in_taken) @(negedge clk_i);
    burst_left--;
    requests_sent++;
  endtask

  task automatic settle();
    if (in_valid_i) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
    end
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NORM_W-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(negedge clk_i);
    while (!cfg_taken) @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic word_t pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3, 4, 5: return word_t'($urandom_range(0, 524288)) - 32'sd262144;
      default: return word_t'($urandom);
    endcase
  endfunction

  initial begin
    word_t edge_set[16];
    int    n;
    int    mats;
    in_valid_i  = 1'b0;
    value_i     = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    edge_set = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 32'shFFFF_FFFF,
                 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh1, 32'sh0001_0000,
                 32'sh0, 32'sh0, 32'shFFFF_0000, 32'sh5555_5555,
                 32'shAAAA_AAAA, 32'sh1, 32'sh8000_0000, 32'sh7FFF_FFFF};
    foreach (edge_set[i]) send_element(edge_set[i]);
    settle();

    write_reg(CFG_SIZE, 16'd0);
    send_element(32'sh8000_0000);
    settle();

    write_reg(CFG_SIZE, 16'd2);
    send_element(32'sh1234_5678);
    settle();
    write_reg(CFG_SIZE, 16'd2);
    repeat (4) send_element('0);
    settle();

    write_reg(CFG_MIN_NORM, 16'hFFFF);
    write_reg(2'd2, 16'hFFFF);
    write_reg(2'd3, 16'h0);
    send_element(32'sh0000_8000);
    send_element(32'sh0000_4000);
    send_element(32'sh0000_C000);
    send_element(32'shFFFF_0000);
    settle();

    while (requests_sent < 350) begin
      write_reg(CFG_SIZE, 16'($urandom_range(0, 7)) | (16'($urandom) & 16'hFFF8));
      case ($urandom_range(0, 5))
        0:       write_reg(CFG_MIN_NORM, 16'($urandom));
        1:       write_reg(CFG_MIN_NORM, 16'hFFFF);
        default: write_reg(CFG_MIN_NORM, 16'h0);
      endcase
      n = (u_checker.order_used());
      mats = $urandom_range(1, 3);
      repeat (mats) begin
        repeat (n * n) send_element(pick_value());
      end
      if ($urandom_range(0, 7) == 0 && n > 1) begin
        repeat ($urandom_range(1, n * n - 1)) send_element(pick_value());
      end
      settle();
    end

    settle();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/qrgr_pkg.sv
sv/qr_givens_rotation_unit.sv
sv/qrgr_checker.sv
dv/qrgr_checker.sv
dv/tb_qr_givens_rotation_unit.sv
